FILE: rtl/core/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every cycle outside reset
`define CHK_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, also checked while reset is active
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/chp_pkg.sv
// shared types, constants and register codes of the chroma hold core
package chp_pkg;

    localparam int KEY_COUNT_DEF = 3;
    localparam int KEY_MAX       = 3;

    localparam int PIX_W    = 8;
    localparam int CTR_W    = 9;
    localparam int SHAPE_F  = 12;
    localparam int GAIN_W   = 9;
    localparam int CENTER_W = 18;
    localparam int SHAPE_W  = 24;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 24;

    // register indexes
    localparam logic [CFG_AW-1:0] REG_KEY_ENABLE = 3'd0;
    localparam logic [CFG_AW-1:0] REG_KEY_BASE   = 3'd1;

    localparam logic [KEY_MAX-1:0]  ENABLE_RST       = 3'd1;
    localparam logic [CENTER_W-1:0] CENTER_RST       = 18'd65664;
    localparam logic [SHAPE_W-1:0]  SHAPE_FIRST_RST  = 24'd4194304;
    localparam logic [SHAPE_W-1:0]  SHAPE_OTHER_RST  = 24'd0;

    localparam logic [GAIN_W-1:0] GAIN_FULL = 9'd256;

    typedef struct packed {
        logic [CENTER_W-1:0] center;
        logic [SHAPE_W-1:0]  shape;
    } t_key_cfg;

endpackage

FILE: rtl/core/chp_key.sv
// per-key gain pipeline: distance, square root, ramp division, gain
module chp_key (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [chp_pkg::PIX_W-1:0]   i_u,
    input  logic [chp_pkg::PIX_W-1:0]   i_v,
    input  chp_pkg::t_key_cfg           i_cfg,
    output logic [chp_pkg::GAIN_W-1:0]  o_gain
);
    import chp_pkg::*;

    localparam int SQ_STEPS  = 14;
    localparam int DIV_STEPS = 9;

    logic [CTR_W-1:0]   cu, cv;
    logic [SHAPE_F-1:0] radius, ramp;
    logic [9:0]         diff_u, diff_v;
    logic [CTR_W-1:0]   n_du, n_dv;
    logic [CTR_W-1:0]   r_du, r_dv;
    logic [17:0]        du_sq, dv_sq;
    logic [19:0]        sq;

    logic [27:0] r_x    [0:SQ_STEPS];
    logic [14:0] r_rem  [0:SQ_STEPS];
    logic [13:0] r_root [0:SQ_STEPS];

    logic [20:0] r_dr   [0:DIV_STEPS];
    logic [8:0]  r_q    [0:DIV_STEPS];
    logic        r_full [0:DIV_STEPS];
    logic        r_zero [0:DIV_STEPS];

    logic [13:0] key_dist, excess;
    logic        n_full, n_zero;
    logic [20:0] n_dvd;
    logic [GAIN_W-1:0] r_gain;

    assign cu     = i_cfg.center[17:9];
    assign cv     = i_cfg.center[8:0];
    assign radius = i_cfg.shape[23:12];
    assign ramp   = i_cfg.shape[11:0];

    // absolute chroma distance per axis
    always_comb begin
        diff_u = {2'b00, i_u} - {1'b0, cu};
        diff_v = {2'b00, i_v} - {1'b0, cv};
        n_du   = diff_u[9] ? 9'(-diff_u) : diff_u[8:0];
        n_dv   = diff_v[9] ? 9'(-diff_v) : diff_v[8:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_du <= n_du;
            r_dv <= n_dv;
        end
    end

    // squared distance, scaled by 256 for the root
    assign du_sq = r_du * r_du;
    assign dv_sq = r_dv * r_dv;
    assign sq    = {2'b00, du_sq} + {2'b00, dv_sq};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= {sq, 8'h00};
            r_rem[0]  <= '0;
            r_root[0] <= '0;
        end
    end

    // square root, one result bit per stage
    for (genvar j = 1; j <= SQ_STEPS; j++) begin : g_sqrt
        logic [16:0] rem_ext, trial;
        always_comb begin
            rem_ext = {r_rem[j-1], r_x[j-1][27:26]};
            trial   = {1'b0, r_root[j-1], 2'b01};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[j] <= {r_x[j-1][25:0], 2'b00};
                if (rem_ext >= trial) begin
                    r_rem[j]  <= 15'(rem_ext - trial);
                    r_root[j] <= {r_root[j-1][12:0], 1'b1};
                end else begin
                    r_rem[j]  <= rem_ext[14:0];
                    r_root[j] <= {r_root[j-1][12:0], 1'b0};
                end
            end
        end
    end

    // compare against radius and ramp, set up the ceiling division
    always_comb begin
        key_dist = r_root[SQ_STEPS];
        excess   = key_dist - {2'b00, radius};
        n_full   = key_dist <= {2'b00, radius};
        n_zero   = (ramp == '0) || (excess > {2'b00, ramp});
        n_dvd    = {1'b0, excess[11:0], 8'h00} + {9'd0, ramp} - 21'd1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dr[0]   <= n_dvd;
            r_q[0]    <= '0;
            r_full[0] <= n_full;
            r_zero[0] <= n_zero;
        end
    end

    // restoring division by the ramp, one quotient bit per stage
    for (genvar b = 1; b <= DIV_STEPS; b++) begin : g_div
        logic [20:0] dvs;
        assign dvs = {9'd0, ramp} << (DIV_STEPS - b);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_full[b] <= r_full[b-1];
                r_zero[b] <= r_zero[b-1];
                if (r_dr[b-1] >= dvs) begin
                    r_dr[b] <= r_dr[b-1] - dvs;
                    r_q[b]  <= r_q[b-1] | (9'd1 << (DIV_STEPS - b));
                end else begin
                    r_dr[b] <= r_dr[b-1];
                    r_q[b]  <= r_q[b-1];
                end
            end
        end
    end

    // final key gain
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            priority if (r_full[DIV_STEPS]) begin
                r_gain <= GAIN_FULL;
            end else if (r_zero[DIV_STEPS]) begin
                r_gain <= '0;
            end else begin
                r_gain <= GAIN_FULL - r_q[DIV_STEPS];
            end
        end
    end

    assign o_gain = r_gain;

endmodule

FILE: rtl/core/chroma_hold_pixel_core.sv
// top level of the chroma hold pixel core
// Colour-key selective desaturation: each (u,v) beat is pulled toward neutral 128 by a gain
// taken as the maximum over the enabled key colours (256 when none is enabled). The core
// takes one beat every clock cycle while the output side does not stall; a result is
// presented once its input beat has passed through 31 register stages, among them the per-key
// 14-stage square root and 9-stage ramp division. A stall on the output side freezes the
// whole pipeline, so s_axis_tready follows m_axis_tready whenever the last stage holds a
// result. Configuration is written through i_cfg_we/i_cfg_addr/i_cfg_wdata and must only
// change while no beat is in flight.
module chroma_hold_pixel_core #(
    parameter int KEY_COUNT = chp_pkg::KEY_COUNT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [chp_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  logic [chp_pkg::CFG_DW-1:0]   i_cfg_wdata,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [15:0]                  s_axis_tdata,  // chroma_u [7:0], chroma_v [15:8]
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [15:0]                  m_axis_tdata   // out_u [7:0], out_v [15:8]
);
    import chp_pkg::*;

    localparam int KEY_LAT = 27;
    localparam int GAIN_ST = KEY_LAT + 1;
    localparam int N_ST    = KEY_LAT + 4;

    logic                  en;
    logic [N_ST-1:0]       r_vld;
    logic [PIX_W-1:0]      r_ud [0:GAIN_ST];
    logic [PIX_W-1:0]      r_vd [0:GAIN_ST];
    logic [KEY_MAX-1:0]    r_enable;
    t_key_cfg              r_key [0:KEY_COUNT-1];
    logic [GAIN_W-1:0]     key_gain [0:KEY_COUNT-1];
    logic [GAIN_W-1:0]     n_gain, r_gain;
    logic                  any_en;
    logic signed [9:0]     cu_s, cv_s;
    logic signed [19:0]    r_pu, r_pv;
    logic signed [19:0]    pu_sh, pv_sh;
    logic [15:0]           r_out;

    // pipeline advances unless the output beat is stuck
    assign en            = !r_vld[N_ST-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = r_vld[N_ST-1];
    assign m_axis_tdata  = r_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= ENABLE_RST;
            for (int k = 0; k < KEY_COUNT; k++) begin
                r_key[k].center <= CENTER_RST;
                r_key[k].shape  <= (k == 0) ? SHAPE_FIRST_RST : SHAPE_OTHER_RST;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_addr == REG_KEY_ENABLE) begin
                r_enable <= i_cfg_wdata[KEY_MAX-1:0];
            end
            for (int k = 0; k < KEY_COUNT; k++) begin
                if (i_cfg_addr == REG_KEY_BASE + CFG_AW'(2 * k)) begin
                    r_key[k].center <= i_cfg_wdata[CENTER_W-1:0];
                end
                if (i_cfg_addr == REG_KEY_BASE + CFG_AW'(2 * k + 1)) begin
                    r_key[k].shape <= i_cfg_wdata[SHAPE_W-1:0];
                end
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[N_ST-2:0], s_axis_tvalid};
        end
    end

    // sample delay line up to the multiply stage
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ud[0] <= s_axis_tdata[7:0];
            r_vd[0] <= s_axis_tdata[15:8];
            for (int i = 1; i <= GAIN_ST; i++) begin
                r_ud[i] <= r_ud[i-1];
                r_vd[i] <= r_vd[i-1];
            end
        end
    end

    for (genvar k = 0; k < KEY_COUNT; k++) begin : g_key
        chp_key u_key (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_u    (r_ud[0]),
            .i_v    (r_vd[0]),
            .i_cfg  (r_key[k]),
            .o_gain (key_gain[k])
        );
    end

    // maximum over enabled keys
    always_comb begin
        n_gain = '0;
        any_en = 1'b0;
        for (int k = 0; k < KEY_COUNT; k++) begin
            if (r_enable[k]) begin
                any_en = 1'b1;
                if (key_gain[k] > n_gain) begin
                    n_gain = key_gain[k];
                end
            end
        end
        if (!any_en) begin
            n_gain = GAIN_FULL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_gain <= n_gain;
        end
    end

    // scale the offset from neutral
    assign cu_s = $signed({2'b00, r_ud[GAIN_ST]}) - 10'sd128;
    assign cv_s = $signed({2'b00, r_vd[GAIN_ST]}) - 10'sd128;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pu <= cu_s * $signed({1'b0, r_gain});
            r_pv <= cv_s * $signed({1'b0, r_gain});
        end
    end

    // arithmetic shift and re-center
    assign pu_sh = r_pu >>> 8;
    assign pv_sh = r_pv >>> 8;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= {pv_sh[7:0] + 8'd128, pu_sh[7:0] + 8'd128};
        end
    end

endmodule

FILE: rtl/core/chp_checker.sv
// port-level checker for the chroma hold pixel core and its bind
`include "assert_macros.svh"

module chp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);
    // no result survives reset
    `CHK_NEXT(a_rst_clear, !i_rst_n, !m_axis_tvalid, "output valid after reset")

    // input side is open exactly when the output slot frees up
    `CHK_IMPL(a_ready_link, 1'b1, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "ready mismatch")

    // a stalled result beat holds
    `CHK_IMPL(a_hold, $past(m_axis_tvalid && !m_axis_tready) && $past(i_rst_n), m_axis_tvalid && $stable(m_axis_tdata), "stalled beat changed")

endmodule

bind chroma_hold_pixel_core chp_checker u_chp_checker (.*);
